// File: hw/rtl/blpw_pkg.sv
// Shared types and constants for the Bresenham line pixel writer.
package blpw_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int ADDR_BITS_DEF  = 27;
  localparam int PITCH_BITS     = 15;
  localparam int FORMAT_BITS    = 2;
  localparam int DATA_BITS      = 32;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = PITCH_BITS;

  typedef enum logic [FORMAT_BITS-1:0] {
    FMT_BGRA   = 2'd0,
    FMT_RGBA   = 2'd1,
    FMT_RGB565 = 2'd2,
    FMT_NONE   = 2'd3
  } fmt_t;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PIXEL_FORMAT = 1'd0,
    CFG_ROW_PITCH    = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    fmt_t                  pixel_format;
    logic [PITCH_BITS-1:0] row_pitch_bytes;
  } cfg_t;

endpackage

// File: hw/rtl/blpw_if.sv
// Valid/ready channel interfaces for line commands and pixel writes.
interface blpw_in_if import blpw_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;

  modport source (output valid, opcode, x_start, y_start, x_end, y_end, red, green, blue,
                  input ready);
  modport sink (input valid, opcode, x_start, y_start, x_end, y_end, red, green, blue,
                output ready);
endinterface

interface blpw_out_if import blpw_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [ADDR_BITS-1:0]  write_address;
  logic [DATA_BITS-1:0]  pixel_data;
  logic                  last;

  modport source (output valid, pixel_x, pixel_y, write_address, pixel_data, last,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, write_address, pixel_data, last,
                output ready);
endinterface

// File: hw/rtl/bresenham_line_pixel_writer.sv
// Top level of the Bresenham line pixel writer.
// A command is registered in the command register and its result in the pixel register.
// Throughput: one command per cycle while the pixel output is not stalled, set by the
// combinational step logic between the command register and the pixel register.
// Reset: synchronous, active low; the writer is idle and the format reads as none.
module bresenham_line_pixel_writer import blpw_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  blpw_in_if.sink                  in_chan,
  blpw_out_if.source               out_chan,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t cfg;

  logic                  s1_valid_r;
  logic                  s1_op_r;
  logic [COORD_BITS-1:0] s1_xs_r, s1_ys_r, s1_xe_r, s1_ye_r;
  logic [7:0]            s1_r_r, s1_g_r, s1_b_r;

  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic [ADDR_BITS-1:0]  out_addr_r;
  logic [DATA_BITS-1:0]  out_data_r;
  logic                  out_last_r;

  logic                  in_xfer, out_free, item_take, res_valid;
  logic [COORD_BITS-1:0] res_x, res_y;
  logic [ADDR_BITS-1:0]  res_addr;
  logic [DATA_BITS-1:0]  res_data;
  logic                  res_last;

  blpw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  blpw_step #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .item_valid    (s1_valid_r),
    .opcode        (s1_op_r),
    .x_start       (s1_xs_r),
    .y_start       (s1_ys_r),
    .x_end         (s1_xe_r),
    .y_end         (s1_ye_r),
    .red           (s1_r_r),
    .green         (s1_g_r),
    .blue          (s1_b_r),
    .out_free      (out_free),
    .item_take     (item_take),
    .res_valid     (res_valid),
    .pixel_x       (res_x),
    .pixel_y       (res_y),
    .write_address (res_addr),
    .pixel_data    (res_data),
    .last          (res_last)
  );

  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || item_take;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (item_take) begin
        s1_valid_r <= 1'b0;
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r <= in_chan.opcode;
      s1_xs_r <= in_chan.x_start;
      s1_ys_r <= in_chan.y_start;
      s1_xe_r <= in_chan.x_end;
      s1_ye_r <= in_chan.y_end;
      s1_r_r  <= in_chan.red;
      s1_g_r  <= in_chan.green;
      s1_b_r  <= in_chan.blue;
    end
    if (res_valid) begin
      out_x_r    <= res_x;
      out_y_r    <= res_y;
      out_addr_r <= res_addr;
      out_data_r <= res_data;
      out_last_r <= res_last;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.pixel_x       = out_x_r;
  assign out_chan.pixel_y       = out_y_r;
  assign out_chan.write_address = out_addr_r;
  assign out_chan.pixel_data    = out_data_r;
  assign out_chan.last          = out_last_r;

endmodule

// File: hw/rtl/blpw_cfg_regs.sv
// Configuration registers: pixel format and row pitch.
module blpw_cfg_regs import blpw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  fmt_t                  format_r;
  logic [PITCH_BITS-1:0] pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r <= FMT_NONE;
      pitch_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PIXEL_FORMAT: format_r <= fmt_t'(cfg_wdata[FORMAT_BITS-1:0]);
        CFG_ROW_PITCH:    pitch_r  <= cfg_wdata[PITCH_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.pixel_format    = format_r;
  assign cfg.row_pitch_bytes = pitch_r;

endmodule

// File: hw/rtl/blpw_step.sv
// Line state and the combinational start and Bresenham step logic.
module blpw_step import blpw_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  item_valid,
  input  logic                  opcode,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic                  out_free,
  output logic                  item_take,
  output logic                  res_valid,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [ADDR_BITS-1:0]  write_address,
  output logic [DATA_BITS-1:0]  pixel_data,
  output logic                  last
);

  localparam int ERR_W  = COORD_BITS + 2;
  localparam int PROD_W = COORD_BITS + PITCH_BITS;
  localparam int SUM_W  = PROD_W + 1;

  logic                    active_r;
  logic [COORD_BITS-1:0]   cur_x_r, cur_y_r, end_x_r, end_y_r, dx_r, dy_r;
  logic                    neg_x_r, neg_y_r;
  logic signed [ERR_W-1:0] err_r;
  logic [ADDR_BITS-1:0]    addr_r;
  logic [DATA_BITS-1:0]    color_r;

  logic                    is_start, fmt_none, fmt_565, produce, upd;
  logic                    x_lt, y_lt;
  logic [COORD_BITS-1:0]   dx_s, dy_s;
  logic signed [ERR_W-1:0] err_s, dx_e, dy_e, e2, err_a;
  logic [DATA_BITS-1:0]    color_s;
  logic [PROD_W-1:0]       prod;
  logic [SUM_W-1:0]        addr_sum;
  logic                    step_x, step_y;
  logic [COORD_BITS-1:0]   x_a, y_a;
  logic [ADDR_BITS-1:0]    offx, offy, addr_x, addr_a;

  logic [COORD_BITS-1:0]   x_nxt, y_nxt;
  logic [ADDR_BITS-1:0]    addr_nxt;
  logic [DATA_BITS-1:0]    color_nxt;
  logic                    last_nxt;

  assign is_start  = (opcode == OP_START);
  assign fmt_none  = (cfg.pixel_format == FMT_NONE);
  assign fmt_565   = (cfg.pixel_format == FMT_RGB565);
  assign produce   = !fmt_none && (is_start || active_r);
  assign item_take = item_valid && (!produce || out_free);
  assign upd       = item_take && produce;

  // Start: deltas, directions, initial error, colour and first address.
  always_comb begin
    x_lt  = (x_start < x_end);
    y_lt  = (y_start < y_end);
    dx_s  = x_lt ? (x_end - x_start) : (x_start - x_end);
    dy_s  = y_lt ? (y_end - y_start) : (y_start - y_end);
    err_s = (dx_s > dy_s) ? ERR_W'(dx_s >> 1) : -ERR_W'(dy_s >> 1);
    case (cfg.pixel_format)
      FMT_BGRA:   color_s = {8'h00, red, green, blue};
      FMT_RGBA:   color_s = {8'h00, blue, green, red};
      FMT_RGB565: color_s = {16'h0000, red[7:3], green[7:2], blue[7:3]};
      default:    color_s = '0;
    endcase
    prod = PROD_W'(y_start) * PROD_W'(cfg.row_pitch_bytes);
    if (fmt_565) begin
      addr_sum = SUM_W'({x_start, 1'b0}) + SUM_W'(prod);
    end else begin
      addr_sum = SUM_W'(x_start) + SUM_W'(prod >> 2);
    end
  end

  // Advance: one Bresenham step with the matching address offsets.
  always_comb begin
    dx_e   = ERR_W'(dx_r);
    dy_e   = ERR_W'(dy_r);
    e2     = err_r;
    step_x = (e2 > -dx_e);
    step_y = (e2 < dy_e);
    err_a  = e2 - (step_x ? dy_e : '0) + (step_y ? dx_e : '0);
    x_a    = step_x ? (neg_x_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1)) : cur_x_r;
    y_a    = step_y ? (neg_y_r ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1)) : cur_y_r;
    offx   = fmt_565 ? ADDR_BITS'(2) : ADDR_BITS'(1);
    offy   = fmt_565 ? ADDR_BITS'(cfg.row_pitch_bytes)
                     : ADDR_BITS'(cfg.row_pitch_bytes >> 2);
    addr_x = step_x ? (neg_x_r ? addr_r - offx : addr_r + offx) : addr_r;
    addr_a = step_y ? (neg_y_r ? addr_x - offy : addr_x + offy) : addr_x;
  end

  always_comb begin
    if (is_start) begin
      x_nxt     = x_start;
      y_nxt     = y_start;
      addr_nxt  = ADDR_BITS'(addr_sum);
      color_nxt = color_s;
      last_nxt  = (x_start == x_end) && (y_start == y_end);
    end else begin
      x_nxt     = x_a;
      y_nxt     = y_a;
      addr_nxt  = addr_a;
      color_nxt = color_r;
      last_nxt  = (x_a == end_x_r) && (y_a == end_y_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (upd) begin
      active_r <= !last_nxt;
    end else if (item_take && is_start) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      cur_x_r <= x_nxt;
      cur_y_r <= y_nxt;
      addr_r  <= addr_nxt;
      color_r <= color_nxt;
      if (is_start) begin
        end_x_r <= x_end;
        end_y_r <= y_end;
        dx_r    <= dx_s;
        dy_r    <= dy_s;
        neg_x_r <= !x_lt;
        neg_y_r <= !y_lt;
        err_r   <= err_s;
      end else begin
        err_r   <= err_a;
      end
    end
  end

  assign res_valid     = upd;
  assign pixel_x       = x_nxt;
  assign pixel_y       = y_nxt;
  assign write_address = addr_nxt;
  assign pixel_data    = color_nxt;
  assign last          = last_nxt;

endmodule

// File: sim/bresenham_line_pixel_writer_test.sv
// Self-checking testbench for the line pixel writer: directed and random lines are checked pixel by pixel.
module bresenham_line_pixel_writer_test import blpw_pkg::*;;

  localparam int COORD_BITS    = COORD_BITS_DEF;
  localparam int ADDR_BITS     = ADDR_BITS_DEF;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int MAX_PITCH     = 16384;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 1000;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    opcode_t    opcode;
    coord_t     x_start;
    coord_t     y_start;
    coord_t     x_end;
    coord_t     y_end;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } line_cmd_t;

  typedef struct {
    coord_t               pixel_x;
    coord_t               pixel_y;
    logic [ADDR_BITS-1:0] write_address;
    logic [DATA_BITS-1:0] pixel_data;
    logic                 last;
  } pixel_write_t;

  class line_scoreboard;
    fmt_t                  pixel_format = FMT_NONE;
    logic [PITCH_BITS-1:0] row_pitch    = '0;
    bit                    active       = 1'b0;
    coord_t                cur_x        = '0;
    coord_t                cur_y        = '0;
    coord_t                end_x        = '0;
    coord_t                end_y        = '0;
    int                    delta_x      = 0;
    int                    delta_y      = 0;
    int                    error_term   = 0;
    bit                    neg_x        = 1'b0;
    bit                    neg_y        = 1'b0;
    logic [ADDR_BITS-1:0]  cur_address  = '0;
    logic [DATA_BITS-1:0]  colour_word  = '0;
    pixel_write_t          expected_pixels[$];
    int                    mismatches   = 0;

    function void write_register(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_PIXEL_FORMAT: pixel_format = fmt_t'(data[FORMAT_BITS-1:0]);
        CFG_ROW_PITCH:    row_pitch = data;
        default:          ;
      endcase
    endfunction

    function void queue_pixel();
      pixel_write_t p;
      p.pixel_x       = cur_x;
      p.pixel_y       = cur_y;
      p.write_address = cur_address;
      p.pixel_data    = colour_word;
      p.last          = (cur_x == end_x) && (cur_y == end_y);
      if (p.last) active = 1'b0;
      expected_pixels.push_back(p);
    endfunction

    function void note_command(line_cmd_t c);
      longint unsigned row_offset;
      longint unsigned step_x;
      longint unsigned step_y;
      int              e2;
      if (c.opcode == OP_START) begin
        if (pixel_format == FMT_NONE) begin
          active = 1'b0;
          return;
        end
        end_x      = c.x_end;
        end_y      = c.y_end;
        cur_x      = c.x_start;
        cur_y      = c.y_start;
        neg_x      = !(c.x_start < c.x_end);
        neg_y      = !(c.y_start < c.y_end);
        delta_x    = neg_x ? int'(c.x_start) - int'(c.x_end) : int'(c.x_end) - int'(c.x_start);
        delta_y    = neg_y ? int'(c.y_start) - int'(c.y_end) : int'(c.y_end) - int'(c.y_start);
        error_term = (delta_x > delta_y) ? delta_x / 2 : -(delta_y / 2);
        case (pixel_format)
          FMT_BGRA: colour_word = {8'h00, c.red, c.green, c.blue};
          FMT_RGBA: colour_word = {8'h00, c.blue, c.green, c.red};
          default:  colour_word = {16'h0000, c.red[7:3], c.green[7:2], c.blue[7:3]};
        endcase
        row_offset = 64'(c.y_start) * 64'(row_pitch);
        if (pixel_format == FMT_RGB565) begin
          cur_address = ADDR_BITS'(2 * 64'(c.x_start) + row_offset);
        end else begin
          cur_address = ADDR_BITS'(64'(c.x_start) + (row_offset >> 2));
        end
        active = 1'b1;
        queue_pixel();
        return;
      end
      if (!active || pixel_format == FMT_NONE) return;
      step_x = (pixel_format == FMT_RGB565) ? 64'd2 : 64'd1;
      step_y = (pixel_format == FMT_RGB565) ? 64'(row_pitch) : 64'(row_pitch) >> 2;
      e2 = error_term;
      if (e2 > -delta_x) begin
        error_term -= delta_y;
        cur_x       = neg_x ? cur_x - coord_t'(1) : cur_x + coord_t'(1);
        cur_address = neg_x ? cur_address - ADDR_BITS'(step_x)
                            : cur_address + ADDR_BITS'(step_x);
      end
      if (e2 < delta_y) begin
        error_term += delta_x;
        cur_y       = neg_y ? cur_y - coord_t'(1) : cur_y + coord_t'(1);
        cur_address = neg_y ? cur_address - ADDR_BITS'(step_y)
                            : cur_address + ADDR_BITS'(step_y);
      end
      queue_pixel();
    endfunction

    function void compare_field(string name, logic [DATA_BITS-1:0] want,
                                logic [DATA_BITS-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pixel(pixel_write_t got);
      pixel_write_t want;
      if (expected_pixels.size() == 0) begin
        $error("Unexpected pixel write at (%0d, %0d)", got.pixel_x, got.pixel_y);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("pixel_x", DATA_BITS'(want.pixel_x), DATA_BITS'(got.pixel_x));
      compare_field("pixel_y", DATA_BITS'(want.pixel_y), DATA_BITS'(got.pixel_y));
      compare_field("write_address", DATA_BITS'(want.write_address),
                    DATA_BITS'(got.write_address));
      compare_field("pixel_data", want.pixel_data, got.pixel_data);
      compare_field("last", DATA_BITS'(want.last), DATA_BITS'(got.last));
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  cfg_idx_t                 cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  idle_mode_t               idle_mode = IDLE_NONE;
  int                       stall_cycles = 0;
  line_scoreboard           pixel_board = new();

  blpw_in_if  in_chan_if ();
  blpw_out_if out_chan_if ();

  bresenham_line_pixel_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan_if),
    .out_chan  (out_chan_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_chan_if.ready <= $urandom_range(0, 99) >= 67;
      IDLE_BOTH:     out_chan_if.ready <= $urandom_range(0, 99) >= 25;
      default:       out_chan_if.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan_if.valid && out_chan_if.ready) begin
        pixel_board.check_pixel(pixel_write_t'{out_chan_if.pixel_x, out_chan_if.pixel_y,
                                               out_chan_if.write_address,
                                               out_chan_if.pixel_data, out_chan_if.last});
      end
      if (in_chan_if.valid && in_chan_if.ready) begin
        pixel_board.note_command(line_cmd_t'{opcode_t'(in_chan_if.opcode),
                                             in_chan_if.x_start, in_chan_if.y_start,
                                             in_chan_if.x_end, in_chan_if.y_end,
                                             in_chan_if.red, in_chan_if.green,
                                             in_chan_if.blue});
      end
      if ((in_chan_if.valid && in_chan_if.ready) ||
          (out_chan_if.valid && out_chan_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic bit sender_waits();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 67;
      IDLE_BOTH:   return $urandom_range(0, 99) < 25;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic line_cmd_t start_cmd(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                                          logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return line_cmd_t'{OP_START, x0, y0, x1, y1, r, g, b};
  endfunction

  // Advance commands carry random endpoint and colour fields, which must be ignored.
  function automatic line_cmd_t advance_cmd();
    return line_cmd_t'{OP_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                       coord_t'($urandom), coord_t'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom)};
  endfunction

  function automatic coord_t nearby(coord_t c, int reach);
    int offset;
    offset = $urandom_range(0, reach);
    if ($urandom_range(0, 1) == 1 && int'(c) >= offset) return coord_t'(c - offset);
    if (int'(c) + offset <= COORD_MAX) return coord_t'(c + offset);
    return coord_t'(c - offset);
  endfunction

  task automatic send_command(input line_cmd_t c);
    while (sender_waits()) begin
      in_chan_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan_if.valid   <= 1'b1;
    in_chan_if.opcode  <= c.opcode;
    in_chan_if.x_start <= c.x_start;
    in_chan_if.y_start <= c.y_start;
    in_chan_if.x_end   <= c.x_end;
    in_chan_if.y_end   <= c.y_end;
    in_chan_if.red     <= c.red;
    in_chan_if.green   <= c.green;
    in_chan_if.blue    <= c.blue;
    @(posedge clk);
    while (!in_chan_if.ready) @(posedge clk);
  endtask

  task automatic drain_pixels();
    in_chan_if.valid <= 1'b0;
    do begin
      while (pixel_board.expected_pixels.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (pixel_board.expected_pixels.size() != 0);
  endtask

  task automatic configure(input fmt_t fmt, input int pitch);
    drain_pixels();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PIXEL_FORMAT;
    cfg_wdata <= CFG_DATA_BITS'(fmt);
    @(posedge clk);
    pixel_board.write_register(CFG_PIXEL_FORMAT, CFG_DATA_BITS'(fmt));
    cfg_index <= CFG_ROW_PITCH;
    cfg_wdata <= CFG_DATA_BITS'(pitch);
    @(posedge clk);
    pixel_board.write_register(CFG_ROW_PITCH, CFG_DATA_BITS'(pitch));
    cfg_we <= 1'b0;
  endtask

  task automatic draw_random_lines(input int item_count);
    int     sent;
    int     reach;
    int     steps;
    int     rise;
    int     advances;
    coord_t x0, y0, x1, y1;
    sent = 0;
    while (sent < item_count) begin
      x0 = coord_t'($urandom);
      y0 = coord_t'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        x1 = coord_t'($urandom);
        y1 = coord_t'($urandom);
      end else begin
        reach = $urandom_range(0, 24);
        x1 = nearby(x0, reach);
        y1 = nearby(y0, reach);
      end
      steps = (x1 > x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
      rise  = (y1 > y0) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
      if (rise > steps) steps = rise;
      case ($urandom_range(0, 9))
        0:       advances = $urandom_range(0, steps);
        1:       advances = steps + $urandom_range(1, 3);
        default: advances = steps;
      endcase
      // Long lines are abandoned early to keep the run short.
      if (advances > 40) advances = $urandom_range(0, 40);
      send_command(start_cmd(x0, y0, x1, y1, 8'($urandom), 8'($urandom), 8'($urandom)));
      sent++;
      repeat (advances) begin
        send_command(advance_cmd());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_PIXEL_FORMAT;
    cfg_wdata           = '0;
    in_chan_if.valid    = 1'b0;
    in_chan_if.opcode   = OP_START;
    in_chan_if.x_start  = '0;
    in_chan_if.y_start  = '0;
    in_chan_if.x_end    = '0;
    in_chan_if.y_end    = '0;
    in_chan_if.red      = '0;
    in_chan_if.green    = '0;
    in_chan_if.blue     = '0;
    out_chan_if.ready   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // The format reads as none after reset, so nothing is drawn yet.
    send_command(start_cmd(12'd10, 12'd20, 12'd30, 12'd40, 8'h11, 8'h22, 8'h33));
    send_command(advance_cmd());

    configure(FMT_BGRA, MAX_PITCH);
    send_command(start_cmd('1, '1, '1, '1, 8'hff, 8'hff, 8'hff));
    send_command(advance_cmd());
    send_command(start_cmd('0, '0, 12'd3, 12'd1, 8'h00, 8'h00, 8'h00));
    repeat (3) send_command(advance_cmd());
    send_command(start_cmd(12'd5, 12'd5, '0, '0, 8'h12, 8'h34, 8'h56));
    repeat (2) send_command(advance_cmd());
    send_command(start_cmd('0, '1, '1, '0, 8'hff, 8'h00, 8'hff));
    repeat (2) send_command(advance_cmd());

    // Registers change while the line is still open.
    configure(FMT_RGB565, 100);
    repeat (2) send_command(advance_cmd());
    configure(FMT_NONE, 100);
    send_command(advance_cmd());
    configure(FMT_RGBA, MAX_PITCH);
    send_command(advance_cmd());

    // A larger pitch after the start makes the address step wrap below zero.
    configure(FMT_BGRA, 0);
    send_command(start_cmd(12'd1, 12'd1, '0, '0, 8'h80, 8'h7f, 8'h01));
    configure(FMT_BGRA, MAX_PITCH);
    send_command(advance_cmd());

    configure(FMT_RGB565, MAX_PITCH);
    send_command(start_cmd('1, '1, '1, 12'd4094, 8'hff, 8'hff, 8'hff));
    send_command(advance_cmd());

    for (int phase = 0; phase < 12; phase++) begin
      fmt_t fmt;
      int   pitch;
      fmt = fmt_t'(phase % 4);
      case (phase)
        0:       pitch = 0;
        1:       pitch = MAX_PITCH;
        2:       pitch = $urandom_range(1, 64);
        default: pitch = $urandom_range(0, MAX_PITCH);
      endcase
      configure(fmt, pitch);
      idle_mode <= idle_mode_t'((phase + phase / 4) % 4);
      draw_random_lines((fmt == FMT_NONE) ? 50 : 180);
    end

    drain_pixels();
    if (pixel_board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
